[hw/rtl/msq_pkg.sv]
// Shared constants, item types and state encoding for the motion sequence queue.
package msq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One queue entry: delay-only flag and a 32-bit value that is the delay of
  // a delay entry or the target of a move.
  localparam int ENTRY_W = 33;

  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_LOAD   = 3'd1;
  localparam logic [2:0] REQ_PAUSE  = 3'd2;
  localparam logic [2:0] REQ_RESUME = 3'd3;
  localparam logic [2:0] REQ_RESET  = 3'd4;
  localparam logic [2:0] REQ_ZERO   = 3'd5;

  localparam logic [2:0] EV_DELAYING  = 3'd0;
  localparam logic [2:0] EV_MOVING    = 3'd1;
  localparam logic [2:0] EV_COMPLETED = 3'd2;
  localparam logic [2:0] EV_PAUSED    = 3'd3;
  localparam logic [2:0] EV_RESUMED   = 3'd4;
  localparam logic [2:0] EV_RESET     = 3'd5;
  localparam logic [2:0] EV_ZERO      = 3'd6;

  localparam logic REG_OWN_ID    = 1'b0;
  localparam logic REG_SPEED_LIM = 1'b1;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [7:0]         dest_id;
    logic               broadcast;
    logic               motor_idle;
    logic               entry_first;
    logic               entry_last;
    logic               entry_is_delay;
    logic signed [31:0] entry_position;
    logic [31:0]        entry_delay;
  } msq_req_t;

  typedef struct packed {
    logic [2:0]         event_res;
    logic signed [31:0] target_position;
    logic [15:0]        target_speed;
    logic               stop_motor;
    logic               home_motor;
    logic [7:0]         source_id;
  } msq_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TICK,
    ST_SCAN,
    ST_EVAL,
    ST_EMIT
  } msq_state_t;

endpackage

[hw/rtl/motion_sequence_queue.sv]
// Stepper axis sequencer: entry queue, command decoder and tick-driven step sequencer.
//
// Usage: commands and millisecond ticks arrive as items on the in_ channel
// (in_valid / in_stall); feedback leaves as items on the out_ channel
// (out_valid / out_stall). Two registers, own_id and the speed limit, are
// written over the cfg_ port, which is always ready; write them only while idle.
//
// Each input item is worked on alone by a small sequencer around one queue
// memory with a registered read port. Starting an entry addresses and then
// evaluates each entry looked at (SCAN, then EVAL) and ends with the result
// (EMIT); at worst the walk covers the whole queue.
//
// A finished result sits in an output register, so the next item is taken
// while the receiver stalls; a second result holds the sequencer until the
// output register is free. Reset (rst_n low, synchronous) empties the queue,
// clears pause, delay and completion state and restores own_id to 1 and the
// speed limit to 1000; queue memory is not cleared, as only written entries are read.
module motion_sequence_queue import msq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  msq_req_t in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output msq_res_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_index,
  input  logic [15:0] cfg_wdata
);

  msq_state_t state_r, state_nxt;

  // Configuration registers.
  logic [7:0]  own_id_r;
  logic [15:0] speed_lim_r;

  // Sequencer state.
  logic [QCNT_W-1:0] entry_count_r, entry_count_nxt;
  logic [QCNT_W-1:0] cur_idx_r, cur_idx_nxt;
  logic              paused_r, paused_nxt;
  logic              delaying_r, delaying_nxt;
  logic              compl_r, compl_nxt;
  logic [31:0]       elapsed_r, elapsed_nxt;

  // Latched item and pending result.
  msq_req_t item_r;
  msq_res_t res_r, res_nxt;

  logic     out_valid_r;
  msq_res_t out_data_r;

  // Queue memory.
  logic               ram_we;
  logic [QIDX_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  msq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(cur_idx_r[QIDX_W-1:0]),
    .rdata(ram_rdata)
  );

  // Decode of the latched item.
  logic is_tick, cmd_ok, is_load;
  assign is_tick = (item_r.req_type == REQ_TICK);
  assign is_load = (item_r.req_type == REQ_LOAD);
  assign cmd_ok  = (item_r.req_type != REQ_TICK) && (item_r.req_type <= REQ_ZERO) &&
                   (item_r.broadcast || (item_r.dest_id == own_id_r));

  // Load path: the first flag restarts the queue before the append.
  logic [QCNT_W-1:0] wr_cnt, cnt_after;
  assign wr_cnt    = item_r.entry_first ? '0 : entry_count_r;
  assign ram_we    = (state_r == ST_DECODE) && cmd_ok && is_load &&
                     (wr_cnt < QCNT_W'(QUEUE_DEPTH));
  assign ram_waddr = wr_cnt[QIDX_W-1:0];
  assign ram_wdata = item_r.entry_is_delay ? {1'b1, item_r.entry_delay}
                                           : {1'b0, item_r.entry_position};
  assign cnt_after = ram_we ? wr_cnt + QCNT_W'(1) : wr_cnt;

  // Entry read from the queue at the current index.
  logic        ent_donly;
  logic [31:0] ent_delay;
  logic [31:0] ent_pos;
  assign ent_donly = ram_rdata[ENTRY_W-1];
  assign ent_delay = ent_donly ? ram_rdata[31:0] : '0;
  assign ent_pos   = ent_donly ? '0 : ram_rdata[31:0];

  // Delay timing: the elapsed count saturates.
  logic [31:0] elapsed_inc;
  logic        expired;
  assign elapsed_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + 32'd1;
  assign expired     = (elapsed_inc >= ent_delay);

  logic              idx_in_range;
  logic [QCNT_W:0]   idx_plus1;
  logic              has_next, at_last;
  assign idx_in_range = (cur_idx_r < entry_count_r);
  assign idx_plus1    = {1'b0, cur_idx_r} + (QCNT_W + 1)'(1);
  assign has_next     = (idx_plus1 < {1'b0, entry_count_r});
  assign at_last      = (idx_plus1 == {1'b0, entry_count_r});

  logic run_step;
  assign run_step = item_r.motor_idle && !paused_r;

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (is_tick) begin
          state_nxt = (entry_count_r == '0) ? ST_IDLE : ST_TICK;
        end else if (!cmd_ok) begin
          state_nxt = ST_IDLE;
        end else if (is_load) begin
          state_nxt = (item_r.entry_last && (cnt_after != '0)) ? ST_SCAN : ST_IDLE;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_TICK: begin
        if (delaying_r) begin
          if (expired) begin
            state_nxt = ent_donly ? ST_SCAN : ST_EMIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else if (run_step && has_next) begin
          state_nxt = ST_SCAN;
        end else if (run_step && at_last && !compl_r) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        state_nxt = idx_in_range ? ST_EVAL : ST_IDLE;
      end
      ST_EVAL: begin
        if (ent_delay == '0 && ent_donly) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer state updates and result formation.
  always_comb begin
    entry_count_nxt = entry_count_r;
    cur_idx_nxt     = cur_idx_r;
    paused_nxt      = paused_r;
    delaying_nxt    = delaying_r;
    compl_nxt       = compl_r;
    elapsed_nxt     = elapsed_r;
    res_nxt         = res_r;
    unique case (state_r)
      ST_DECODE: begin
        res_nxt           = '0;
        res_nxt.source_id = own_id_r;
        if (cmd_ok) begin
          case (item_r.req_type)
            REQ_LOAD: begin
              entry_count_nxt = cnt_after;
              if (item_r.entry_first) begin
                cur_idx_nxt = '0;
              end
              if (item_r.entry_last) begin
                compl_nxt = 1'b0;
              end
            end
            REQ_PAUSE: begin
              paused_nxt        = 1'b1;
              res_nxt.event_res = EV_PAUSED;
            end
            REQ_RESUME: begin
              paused_nxt        = 1'b0;
              res_nxt.event_res = EV_RESUMED;
            end
            REQ_RESET, REQ_ZERO: begin
              paused_nxt         = 1'b0;
              delaying_nxt       = 1'b0;
              entry_count_nxt    = '0;
              cur_idx_nxt        = '0;
              res_nxt.event_res  = (item_r.req_type == REQ_RESET) ? EV_RESET : EV_ZERO;
              res_nxt.stop_motor = (item_r.req_type == REQ_RESET);
              res_nxt.home_motor = (item_r.req_type == REQ_ZERO);
            end
            default: ;
          endcase
        end
      end
      ST_TICK: begin
        if (delaying_r) begin
          elapsed_nxt = elapsed_inc;
          if (expired) begin
            delaying_nxt = 1'b0;
            if (ent_donly) begin
              cur_idx_nxt = idx_plus1[QCNT_W-1:0];
            end else begin
              res_nxt.event_res       = EV_MOVING;
              res_nxt.target_position = ent_pos;
              res_nxt.target_speed    = speed_lim_r;
            end
          end
        end else if (run_step && has_next) begin
          cur_idx_nxt = idx_plus1[QCNT_W-1:0];
        end else if (run_step && at_last && !compl_r) begin
          compl_nxt         = 1'b1;
          res_nxt.event_res = EV_COMPLETED;
        end
      end
      ST_EVAL: begin
        if (ent_delay != '0) begin
          delaying_nxt      = 1'b1;
          elapsed_nxt       = '0;
          res_nxt.event_res = EV_DELAYING;
        end else if (ent_donly) begin
          cur_idx_nxt = idx_plus1[QCNT_W-1:0];
        end else begin
          res_nxt.event_res       = EV_MOVING;
          res_nxt.target_position = ent_pos;
          res_nxt.target_speed    = speed_lim_r;
        end
      end
      ST_IDLE, ST_SCAN, ST_EMIT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      own_id_r      <= 8'd1;
      speed_lim_r   <= 16'd1000;
      entry_count_r <= '0;
      cur_idx_r     <= '0;
      paused_r      <= 1'b0;
      delaying_r    <= 1'b0;
      compl_r       <= 1'b0;
      elapsed_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      entry_count_r <= entry_count_nxt;
      cur_idx_r     <= cur_idx_nxt;
      paused_r      <= paused_nxt;
      delaying_r    <= delaying_nxt;
      compl_r       <= compl_nxt;
      elapsed_r     <= elapsed_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_OWN_ID:    own_id_r    <= cfg_wdata[7:0];
          REG_SPEED_LIM: speed_lim_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      item_r <= in_data;
    end
    res_r <= res_nxt;
    if (state_r == ST_EMIT && out_free) begin
      out_data_r <= res_r;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hw/rtl/msq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module msq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/msq_checker.sv]
// Port-level checks for the motion sequence queue and their binding to the top level.
module msq_checker import msq_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input msq_res_t out_data
);

  // A result that is stalled stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // The sequencer works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted while busy");

  // Stop and home requests travel only with their own events.
  a_stop_home: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.stop_motor == (out_data.event_res == EV_RESET)) &&
                  (out_data.home_motor == (out_data.event_res == EV_ZERO)))
    else $error("stop or home flag on wrong event");

  // Only a moving event carries a target.
  a_target_only_moving: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_res != EV_MOVING) |->
      (out_data.target_position == '0) && (out_data.target_speed == '0))
    else $error("target on a non-moving event");

endmodule

bind motion_sequence_queue msq_checker u_msq_checker (.*);
